@@ rtl/core/lrdr_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// lrdr_pkg
// shared types, constants and ripple tables of the ripple drop renderer
// ---------------------------------------------------------------------------
package lrdr_pkg;

  localparam int STRIP_LENGTH = 64;
  localparam int DROP_SLOTS   = 16;

  localparam int DRAW_W    = 7;
  localparam int POS_W     = 6;
  localparam int LED_W     = 6;
  localparam int BRIGHT_W  = 8;
  localparam int STAGE_W   = 4;
  localparam int MAXL_W    = 5;
  localparam int CHANCE_W  = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;

  localparam int SLOT_W  = (DROP_SLOTS > 1) ? $clog2(DROP_SLOTS) : 1;
  localparam int CNT_W   = $clog2(DROP_SLOTS + 1);
  localparam int SUM_W   = CNT_W + 1;
  localparam int LIM_W   = (CNT_W > MAXL_W) ? CNT_W : MAXL_W;
  localparam int ADDR_W  = $clog2(STRIP_LENGTH);
  localparam int ISS_W   = $clog2(STRIP_LENGTH + 1);
  localparam int REACH_W = 3;
  localparam int OFS_W   = 4;

  localparam logic [STAGE_W-1:0] LAST_PAINT_STAGE = STAGE_W'(8);
  localparam logic [STAGE_W-1:0] RETIRE_STAGE     = STAGE_W'(9);
  localparam logic [STAGE_W-1:0] STAGE_MAX        = STAGE_W'(15);

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_LIVE   = 2'd0,
    CFG_ADD_CHANCE = 2'd1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAINT,
    ST_RETIRE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic             add;
    logic [POS_W-1:0] add_pos;
    logic             inc;
    logic             retire;
  } ring_cmd_t;

  typedef struct packed {
    logic                clr;
    logic                wr;
    logic [ADDR_W-1:0]   wr_addr;
    logic [BRIGHT_W-1:0] wr_data;
    logic                rd;
    logic [ADDR_W-1:0]   rd_addr;
  } fb_cmd_t;

  function automatic slot_t slot_add(input slot_t base, input cnt_t ofs);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(ofs);
    if (sum >= SUM_W'(DROP_SLOTS)) begin
      sum = sum - SUM_W'(DROP_SLOTS);
    end
    return sum[SLOT_W-1:0];
  endfunction

  function automatic logic [REACH_W-1:0] ripple_reach(input logic [STAGE_W-1:0] st);
    logic [REACH_W-1:0] r;
    case (st)
      4'd0:    r = 3'd0;
      4'd1:    r = 3'd1;
      4'd2:    r = 3'd2;
      4'd3:    r = 3'd3;
      4'd4:    r = 3'd3;
      4'd5:    r = 3'd4;
      4'd6:    r = 3'd4;
      4'd7:    r = 3'd4;
      4'd8:    r = 3'd4;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [BRIGHT_W-1:0] ripple_level(input logic [STAGE_W-1:0] st,
                                                       input logic [REACH_W-1:0] delta);
    logic [BRIGHT_W-1:0] l;
    l = 8'd0;
    case (st)
      4'd0: begin
        if (delta == 3'd0) l = 8'd255;
      end
      4'd1: begin
        case (delta)
          3'd0:    l = 8'd200;
          3'd1:    l = 8'd255;
          default: l = 8'd0;
        endcase
      end
      4'd2: begin
        case (delta)
          3'd0:    l = 8'd150;
          3'd1:    l = 8'd200;
          3'd2:    l = 8'd255;
          default: l = 8'd0;
        endcase
      end
      4'd3: begin
        case (delta)
          3'd1:    l = 8'd150;
          3'd2:    l = 8'd200;
          3'd3:    l = 8'd150;
          default: l = 8'd0;
        endcase
      end
      4'd4: begin
        case (delta)
          3'd1:    l = 8'd100;
          3'd2:    l = 8'd150;
          3'd3:    l = 8'd100;
          default: l = 8'd0;
        endcase
      end
      4'd5: begin
        case (delta)
          3'd1:    l = 8'd50;
          3'd2:    l = 8'd80;
          3'd3:    l = 8'd100;
          3'd4:    l = 8'd80;
          default: l = 8'd0;
        endcase
      end
      4'd6: begin
        case (delta)
          3'd2:    l = 8'd25;
          3'd3:    l = 8'd50;
          3'd4:    l = 8'd25;
          default: l = 8'd0;
        endcase
      end
      4'd7: begin
        case (delta)
          3'd2:    l = 8'd5;
          3'd3:    l = 8'd25;
          3'd4:    l = 8'd5;
          default: l = 8'd0;
        endcase
      end
      4'd8: begin
        case (delta)
          3'd2:    l = 8'd3;
          3'd3:    l = 8'd20;
          3'd4:    l = 8'd3;
          default: l = 8'd0;
        endcase
      end
      default: l = 8'd0;
    endcase
    return l;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/lrdr_in_if.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// lrdr_in_if
// tick channel: random draw and position of a possible new drop
// ---------------------------------------------------------------------------
interface lrdr_in_if import lrdr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DRAW_W-1:0] chance_draw;
  logic [POS_W-1:0]  new_drop_position;

  modport source (output valid, output chance_draw, output new_drop_position, input ready);
  modport sink (input valid, input chance_draw, input new_drop_position, output ready);
endinterface
`default_nettype wire

@@ rtl/core/lrdr_out_if.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// lrdr_out_if
// result channel: one led brightness per transaction
// ---------------------------------------------------------------------------
interface lrdr_out_if import lrdr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [LED_W-1:0]    led_index;
  logic [BRIGHT_W-1:0] led_brightness;
  logic                last_led;

  modport source (output valid, output led_index, output led_brightness, output last_led,
                  input ready);
  modport sink (input valid, input led_index, input led_brightness, input last_led,
                output ready);
endinterface
`default_nettype wire

@@ rtl/core/lrdr_cfg_if.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// lrdr_cfg_if
// configuration write channel: register index and write data
// ---------------------------------------------------------------------------
interface lrdr_cfg_if import lrdr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/lrdr_ring.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// lrdr_ring
// ring of live drops: positions, stages, oldest slot and live count
// ---------------------------------------------------------------------------
module lrdr_ring import lrdr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  ring_cmd_t          cmd,
  input  cnt_t               rd_k,
  output logic [POS_W-1:0]   rd_pos,
  output logic [STAGE_W-1:0] rd_stage,
  output cnt_t               count
);

  logic [POS_W-1:0]   pos_r   [DROP_SLOTS];
  logic [STAGE_W-1:0] stage_r [DROP_SLOTS];
  slot_t              oldest_r, oldest_nxt;
  cnt_t               count_r, count_nxt;
  slot_t              add_slot;
  slot_t              rd_slot;
  logic               do_retire;

  assign add_slot  = slot_add(oldest_r, count_r);
  assign rd_slot   = slot_add(oldest_r, rd_k);
  assign rd_pos    = pos_r[rd_slot];
  assign rd_stage  = stage_r[rd_slot];
  assign count     = count_r;
  assign do_retire = cmd.retire && (count_r != '0) && (stage_r[oldest_r] > RETIRE_STAGE);

  always_comb begin
    oldest_nxt = oldest_r;
    count_nxt  = count_r;
    if (cmd.add) begin
      count_nxt = count_r + cnt_t'(1);
    end
    if (do_retire) begin
      oldest_nxt = slot_add(oldest_r, cnt_t'(1));
      count_nxt  = count_r - cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r <= '0;
      count_r  <= '0;
    end else begin
      oldest_r <= oldest_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add) begin
      pos_r[add_slot]   <= cmd.add_pos;
      stage_r[add_slot] <= '0;
    end
    if (cmd.inc && (stage_r[rd_slot] != STAGE_MAX)) begin
      stage_r[rd_slot] <= stage_r[rd_slot] + STAGE_W'(1);
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/lrdr_fbuf.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// lrdr_fbuf
// brightness frame buffer with per-led written flags and registered read
// ---------------------------------------------------------------------------
module lrdr_fbuf import lrdr_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  fb_cmd_t             cmd,
  output logic [BRIGHT_W-1:0] rd_data
);

  logic [BRIGHT_W-1:0]     mem [STRIP_LENGTH];
  logic [STRIP_LENGTH-1:0] written_r;
  logic [BRIGHT_W-1:0]     mem_q_r;
  logic                    written_q_r;

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[cmd.wr_addr] <= cmd.wr_data;
    end
    if (cmd.rd) begin
      mem_q_r <= mem[cmd.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r   <= '0;
      written_q_r <= 1'b0;
    end else begin
      if (cmd.clr) begin
        written_r <= '0;
      end else if (cmd.wr) begin
        written_r[cmd.wr_addr] <= 1'b1;
      end
      if (cmd.rd) begin
        written_q_r <= written_r[cmd.rd_addr];
      end
    end
  end

  assign rd_data = written_q_r ? mem_q_r : '0;

endmodule
`default_nettype wire

@@ rtl/core/led_ripple_drop_renderer_core.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// led_ripple_drop_renderer_core
// ripple drop renderer: one tick in, one brightness per led out
// ---------------------------------------------------------------------------
// Each accepted tick may add a drop, repaints the frame from every live drop
// (oldest first) and then streams all STRIP_LENGTH led brightnesses, index
// order, last_led on the final one. After the tick is accepted, painting
// visits every led position of each live drop (2*reach+1 positions for
// stages 0 to 8, none written for a finished drop), then steps past the list,
// retires the oldest drop once its stage has passed RETIRE_STAGE and emits.
// The pace is set by the single paint address unit, which writes one led
// per cycle, and by the single read port of the frame buffer. in_ch.ready is
// high only between ticks; configuration writes are taken at any time.
module led_ripple_drop_renderer_core import lrdr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  lrdr_in_if.sink   in_ch,
  lrdr_out_if.source out_ch,
  lrdr_cfg_if.sink  cfg_ch
);

  state_t state_r, state_nxt;

  logic [MAXL_W-1:0]   max_live_r;
  logic [CHANCE_W-1:0] chance_r;

  cnt_t                k_r, k_nxt;
  logic [OFS_W-1:0]    ofs_r, ofs_nxt;
  logic [ISS_W-1:0]    iss_r, iss_nxt;
  logic                pend_r, pend_nxt;
  logic [LED_W-1:0]    pend_idx_r;

  logic                out_valid_r;
  logic [LED_W-1:0]    out_idx_r;
  logic [BRIGHT_W-1:0] out_bright_r;
  logic                out_last_r;

  ring_cmd_t           ring_cmd;
  fb_cmd_t             fb_cmd;
  logic [POS_W-1:0]    rd_pos;
  logic [STAGE_W-1:0]  rd_stage;
  cnt_t                live_count;
  logic [BRIGHT_W-1:0] fb_rd_data;

  logic                in_fire;
  logic                add_ok;
  logic [LIM_W-1:0]    limit;
  logic                list_done;
  logic                stage_dead;
  logic [REACH_W-1:0]  reach;
  logic [OFS_W:0]      delta;
  logic [REACH_W-1:0]  delta_abs;
  logic [ADDR_W+2:0]   led_pos;
  logic                on_strip;
  logic                drop_done;
  logic                emit_done;
  logic                load;
  logic                issue;

  lrdr_ring u_ring (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (ring_cmd),
    .rd_k     (k_r),
    .rd_pos   (rd_pos),
    .rd_stage (rd_stage),
    .count    (live_count)
  );

  lrdr_fbuf u_fbuf (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (fb_cmd),
    .rd_data (fb_rd_data)
  );

  // configuration
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_live_r <= MAXL_W'(8);
      chance_r   <= CHANCE_W'(20);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_MAX_LIVE:   max_live_r <= cfg_ch.data[MAXL_W-1:0];
        CFG_ADD_CHANCE: chance_r   <= cfg_ch.data[CHANCE_W-1:0];
        default: ;
      endcase
    end
  end

  // add decision
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign limit       = (LIM_W'(max_live_r) > LIM_W'(DROP_SLOTS)) ? LIM_W'(DROP_SLOTS)
                                                                 : LIM_W'(max_live_r);
  assign add_ok      = (LIM_W'(live_count) < limit) && (in_ch.chance_draw < chance_r);

  // shared paint address unit
  assign list_done  = (k_r == live_count);
  assign stage_dead = (rd_stage > LAST_PAINT_STAGE);
  assign reach      = ripple_reach(rd_stage);
  assign delta      = {1'b0, ofs_r} - {2'b00, reach};
  assign delta_abs  = delta[OFS_W] ? REACH_W'(-delta) : delta[REACH_W-1:0];
  assign led_pos    = (ADDR_W+3)'(rd_pos) + {{(ADDR_W+3-OFS_W-1){delta[OFS_W]}}, delta};
  assign on_strip   = !led_pos[ADDR_W+2] && (led_pos < (ADDR_W+3)'(STRIP_LENGTH));
  assign drop_done  = stage_dead || (ofs_r == {reach, 1'b0});

  // emit pipeline
  assign load      = pend_r && (!out_valid_r || out_ch.ready);
  assign emit_done = (iss_r == ISS_W'(STRIP_LENGTH)) && !pend_r;
  assign issue     = (state_r == ST_EMIT) && (iss_r != ISS_W'(STRIP_LENGTH)) &&
                     (!pend_r || load);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_PAINT;
      end
      ST_PAINT: begin
        if (list_done) state_nxt = ST_RETIRE;
      end
      ST_RETIRE: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_done) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ring_cmd         = '0;
    ring_cmd.add_pos = in_ch.new_drop_position;
    fb_cmd           = '0;
    fb_cmd.wr_addr   = led_pos[ADDR_W-1:0];
    fb_cmd.wr_data   = ripple_level(rd_stage, delta_abs);
    fb_cmd.rd_addr   = iss_r[ADDR_W-1:0];
    fb_cmd.rd        = issue;
    k_nxt            = k_r;
    ofs_nxt          = ofs_r;
    iss_nxt          = iss_r;
    pend_nxt         = issue || (pend_r && !load);
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          ring_cmd.add = add_ok;
          fb_cmd.clr   = 1'b1;
          k_nxt        = '0;
          ofs_nxt      = '0;
        end
      end
      ST_PAINT: begin
        if (!list_done) begin
          fb_cmd.wr = !stage_dead && on_strip;
          if (drop_done) begin
            ring_cmd.inc = 1'b1;
            k_nxt        = k_r + cnt_t'(1);
            ofs_nxt      = '0;
          end else begin
            ofs_nxt = ofs_r + OFS_W'(1);
          end
        end
      end
      ST_RETIRE: begin
        ring_cmd.retire = 1'b1;
        iss_nxt         = '0;
      end
      ST_EMIT: begin
        if (issue) iss_nxt = iss_r + ISS_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      ofs_r       <= '0;
      iss_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      ofs_r   <= ofs_nxt;
      iss_r   <= iss_nxt;
      pend_r  <= pend_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      pend_idx_r <= iss_r[LED_W-1:0];
    end
    if (load) begin
      out_idx_r    <= pend_idx_r;
      out_bright_r <= fb_rd_data;
      out_last_r   <= (pend_idx_r == LED_W'(STRIP_LENGTH - 1));
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.led_index      = out_idx_r;
  assign out_ch.led_brightness = out_bright_r;
  assign out_ch.last_led       = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_count <= cnt_t'(DROP_SLOTS))
    else $error("live drop count beyond slot count");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (live_count == $past(live_count)) ||
                     (live_count == $past(live_count) + cnt_t'(1)) ||
                     (live_count == $past(live_count) - cnt_t'(1)))
    else $error("live drop count moved by more than one");

  a_write_in_paint: assert property (@(posedge clk) disable iff (!rst_n)
    fb_cmd.wr |-> (state_r == ST_PAINT))
    else $error("frame buffer written outside painting");

  a_pend_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == ST_EMIT))
    else $error("read data pending outside emit");

endmodule
`default_nettype wire
